FILE: hw/rtl/fscp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fscp_pkg
// Shared codes and types for the framed servo command parser.
// ----------------------------------------------------------------------------
package fscp_pkg;

  localparam logic [7:0] HEAD_BYTE = 8'hAA;
  localparam logic [7:0] TAIL_BYTE = 8'hA5;
  localparam logic [7:0] MAX_ANGLE = 8'd180;
  localparam logic [3:0] CH_LOW    = 4'd13;
  localparam logic [3:0] CH_HIGH   = 4'd14;

  // tokenizer phases
  localparam logic [3:0] PH_START = 4'd0;
  localparam logic [3:0] PH_SIGN1 = 4'd1;
  localparam logic [3:0] PH_DIG1  = 4'd2;
  localparam logic [3:0] PH_GAP   = 4'd3;
  localparam logic [3:0] PH_NEED2 = 4'd4;
  localparam logic [3:0] PH_SIGN2 = 4'd5;
  localparam logic [3:0] PH_DIG2  = 4'd6;
  localparam logic [3:0] PH_TRAIL = 4'd7;
  localparam logic [3:0] PH_BAD   = 4'd15;

  // result status
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_LONG = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  // event kinds passed from front to back
  localparam logic [1:0] EV_TAIL = 2'd0;
  localparam logic [1:0] EV_LONG = 2'd1;
  localparam logic [1:0] EV_OVF  = 2'd2;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] phase;
    logic [7:0] first_mag;
    logic       first_negative;
    logic [7:0] second_mag;
    logic       second_negative;
  } evt_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage : fscp_pkg
`default_nettype wire

FILE: hw/rtl/fscp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fscp_if
// Valid/ready channels: received word in, parsed result out.
// ----------------------------------------------------------------------------
interface fscp_byte_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_byte;

  modport source (output valid, output func, output data_byte, input ready);
  modport sink   (input valid, input func, input data_byte, output ready);
endinterface : fscp_byte_if

interface fscp_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] channel;
  logic [7:0] angle;

  modport source (output valid, output status, output channel, output angle, input ready);
  modport sink   (input valid, input status, input channel, input angle, output ready);
endinterface : fscp_result_if
`default_nettype wire

FILE: hw/rtl/fscp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fscp_front
// Frame tracking and running tokenizer; emits one event per result.
// ----------------------------------------------------------------------------
module fscp_front #(
  parameter int unsigned FRAME_BYTES = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic          func,
  input  wire logic [7:0]    data_byte,
  output logic               push,
  output fscp_pkg::evt_t     evt
);
  import fscp_pkg::*;

  localparam int unsigned CNT_W = $clog2(FRAME_BYTES);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(FRAME_BYTES - 1);

  logic             frame_open_r, frame_open_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [3:0]       phase_r, phase_nxt;
  logic [7:0]       fv_r, fv_nxt, sv_r, sv_nxt;
  logic             fn_r, fn_nxt, sn_r, sn_nxt, trunc_r, trunc_nxt;

  logic [3:0] fp;
  logic [7:0] ffv, fsv;
  logic       ffn, fsn;

  function automatic logic [7:0] accum(input logic [7:0] v, input logic [7:0] c);
    logic [11:0] n;
    n = 12'({v, 3'b000}) + 12'({v, 1'b0}) + 12'(c - 8'h30);
    return (n > 12'd255) ? 8'd255 : n[7:0];
  endfunction

  logic c_blank, c_vf, c_digit, c_sign, c_minus;
  assign c_blank = (data_byte == 8'h20) || (data_byte == 8'h09) ||
                   (data_byte == 8'h0D) || (data_byte == 8'h0A);
  assign c_vf    = (data_byte == 8'h0B) || (data_byte == 8'h0C);
  assign c_digit = (data_byte >= 8'h30) && (data_byte <= 8'h39);
  assign c_minus = (data_byte == 8'h2D);
  assign c_sign  = (data_byte == 8'h2B) || c_minus;

  // tokenizer step on one payload character
  always_comb begin
    fp  = PH_BAD;
    ffv = fv_r;
    ffn = fn_r;
    fsv = sv_r;
    fsn = sn_r;
    case (phase_r)
      PH_START: begin
        if (c_blank || c_vf) fp = PH_START;
        else if (c_sign) begin
          ffn = c_minus;
          fp  = PH_SIGN1;
        end else if (c_digit) begin
          ffv = accum(fv_r, data_byte);
          fp  = PH_DIG1;
        end
      end
      PH_SIGN1, PH_DIG1: begin
        if (c_digit) begin
          ffv = accum(fv_r, data_byte);
          fp  = PH_DIG1;
        end else if (phase_r == PH_DIG1) begin
          if (c_blank) fp = PH_GAP;
          else if (c_vf) fp = PH_NEED2;
          else if (c_sign) begin
            fsn = c_minus;
            fp  = PH_SIGN2;
          end
        end
      end
      PH_GAP, PH_NEED2: begin
        if (c_blank) fp = phase_r;
        else if (c_vf) fp = PH_NEED2;
        else if (c_sign) begin
          fsn = c_minus;
          fp  = PH_SIGN2;
        end else if (c_digit) begin
          fsv = accum(sv_r, data_byte);
          fp  = PH_DIG2;
        end
      end
      PH_SIGN2, PH_DIG2: begin
        if (c_digit) begin
          fsv = accum(sv_r, data_byte);
          fp  = PH_DIG2;
        end else if (phase_r == PH_DIG2 && c_blank) fp = PH_TRAIL;
      end
      PH_TRAIL: begin
        if (c_blank) fp = PH_TRAIL;
      end
      default: fp = PH_BAD;
    endcase
  end

  always_comb begin
    frame_open_nxt = frame_open_r;
    count_nxt      = count_r;
    phase_nxt      = phase_r;
    fv_nxt         = fv_r;
    fn_nxt         = fn_r;
    sv_nxt         = sv_r;
    sn_nxt         = sn_r;
    trunc_nxt      = trunc_r;
    push           = 1'b0;
    evt.kind            = EV_TAIL;
    evt.phase           = phase_r;
    evt.first_mag       = fv_r;
    evt.first_negative  = fn_r;
    evt.second_mag      = sv_r;
    evt.second_negative = sn_r;

    if (accept) begin
      if (func || data_byte == HEAD_BYTE || data_byte == TAIL_BYTE ||
          (frame_open_r && count_r == CNT_LIMIT)) begin
        frame_open_nxt = 1'b0;
        count_nxt      = '0;
        phase_nxt      = PH_START;
        fv_nxt         = '0;
        fn_nxt         = 1'b0;
        sv_nxt         = '0;
        sn_nxt         = 1'b0;
        trunc_nxt      = 1'b0;
        if (func) begin
          push     = 1'b1;
          evt.kind = EV_OVF;
        end else if (data_byte == HEAD_BYTE) begin
          frame_open_nxt = 1'b1;
        end else if (data_byte == TAIL_BYTE) begin
          push = frame_open_r;
        end else begin
          push     = 1'b1;
          evt.kind = EV_LONG;
        end
      end else if (frame_open_r) begin
        count_nxt = count_r + 1'b1;
        if (!trunc_r) begin
          if (data_byte == 8'h00) trunc_nxt = 1'b1;
          else begin
            phase_nxt = fp;
            fv_nxt    = ffv;
            fn_nxt    = ffn;
            sv_nxt    = fsv;
            sn_nxt    = fsn;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
      count_r      <= '0;
      phase_r      <= PH_START;
      fv_r         <= '0;
      fn_r         <= 1'b0;
      sv_r         <= '0;
      sn_r         <= 1'b0;
      trunc_r      <= 1'b0;
    end else begin
      frame_open_r <= frame_open_nxt;
      count_r      <= count_nxt;
      phase_r      <= phase_nxt;
      fv_r         <= fv_nxt;
      fn_r         <= fn_nxt;
      sv_r         <= sv_nxt;
      sn_r         <= sn_nxt;
      trunc_r      <= trunc_nxt;
    end
  end

endmodule : fscp_front
`default_nettype wire

FILE: hw/rtl/fscp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fscp_queue
// Short event queue between tokenizer and result stage.
// ----------------------------------------------------------------------------
module fscp_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire fscp_pkg::evt_t   wr_data,
  input  wire logic             pop,
  output fscp_pkg::evt_t        rd_data,
  output fscp_pkg::q_stat_t     stat
);
  import fscp_pkg::*;

  evt_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   count_r, count_nxt;

  assign stat.full  = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign stat.empty = (count_r == '0);
  assign rd_data    = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

endmodule : fscp_queue
`default_nettype wire

FILE: hw/rtl/fscp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fscp_back
// Judges a queued event and holds the result word for the sink.
// ----------------------------------------------------------------------------
module fscp_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire fscp_pkg::evt_t    evt,
  input  wire fscp_pkg::q_stat_t q_stat,
  output logic                   pop,
  fscp_result_if.source          out_ch
);
  import fscp_pkg::*;

  logic       valid_r;
  logic [1:0] status_r, status_nxt;
  logic [3:0] channel_r, channel_nxt;
  logic [7:0] angle_r, angle_nxt;

  logic ok;
  logic [3:0] ch;
  logic [7:0] ang;

  function automatic logic angle_ok(input logic [7:0] v, input logic neg);
    return neg ? (v == 8'd0) : (v <= MAX_ANGLE);
  endfunction

  always_comb begin
    ok  = 1'b0;
    ch  = CH_HIGH;
    ang = evt.first_negative ? 8'd0 : evt.first_mag;
    case (evt.phase)
      PH_DIG1, PH_GAP: begin
        ok = angle_ok(evt.first_mag, evt.first_negative);
      end
      PH_DIG2, PH_TRAIL: begin
        ok  = angle_ok(evt.second_mag, evt.second_negative) && !evt.first_negative &&
              (evt.first_mag == 8'(CH_LOW) || evt.first_mag == 8'(CH_HIGH));
        ch  = evt.first_mag[3:0];
        ang = evt.second_negative ? 8'd0 : evt.second_mag;
      end
      default: ok = 1'b0;
    endcase

    status_nxt  = ST_BAD;
    channel_nxt = '0;
    angle_nxt   = '0;
    case (evt.kind)
      EV_OVF:  status_nxt = ST_OVF;
      EV_LONG: status_nxt = ST_LONG;
      EV_TAIL: begin
        if (ok) begin
          status_nxt  = ST_OK;
          channel_nxt = ch;
          angle_nxt   = ang;
        end
      end
      default: status_nxt = ST_BAD;
    endcase
  end

  assign pop = !q_stat.empty && (!valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status_r  <= status_nxt;
      channel_r <= channel_nxt;
      angle_r   <= angle_nxt;
    end
  end

  assign out_ch.valid   = valid_r;
  assign out_ch.status  = status_r;
  assign out_ch.channel = channel_r;
  assign out_ch.angle   = angle_r;

endmodule : fscp_back
`default_nettype wire

FILE: hw/rtl/framed_servo_command_parser_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// framed_servo_command_parser_top
// Framed text servo command parser: bytes in, status/channel/angle out.
// ----------------------------------------------------------------------------
//  channel   dir  words               payload
//  in_ch     in   func + byte         func, data_byte
//  out_ch    out  one per result      status, channel, angle
//
//  One input word per cycle while the queue has room; the tokenizer
//  updates its state in the cycle it takes a byte.
//  A result word passes through the four-entry event queue and then the
//  output register.
//  Input stalls only when the event queue is full; output stalls back up
//  into the queue. Synchronous active-low reset clears frame and queue.
// ----------------------------------------------------------------------------
module framed_servo_command_parser_top #(
  parameter int unsigned FRAME_BYTES = 32
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  fscp_byte_if.sink      in_ch,
  fscp_result_if.source  out_ch
);
  import fscp_pkg::*;

  logic    push, pop, accept;
  evt_t    wr_evt, rd_evt;
  q_stat_t q_stat;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;

  fscp_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .func      (in_ch.func),
    .data_byte (in_ch.data_byte),
    .push      (push),
    .evt       (wr_evt)
  );

  fscp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (wr_evt),
    .pop     (pop),
    .rd_data (rd_evt),
    .stat    (q_stat)
  );

  fscp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .evt    (rd_evt),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !in_ch.ready)
    else $error("input taken with event queue full");

  a_ovf_queued: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.func |=> !q_stat.empty)
    else $error("overflow notice not queued");

  a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == ST_OK |->
      (out_ch.channel == CH_LOW || out_ch.channel == CH_HIGH) &&
      out_ch.angle <= MAX_ANGLE)
    else $error("ok result out of range");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != ST_OK |->
      out_ch.channel == 4'd0 && out_ch.angle == 8'd0)
    else $error("error result carries channel or angle");

endmodule : framed_servo_command_parser_top
`default_nettype wire

FILE: dv/fscp_command_checker.sv
// ----------------------------------------------------------------------------
// fscp_command_checker
// Watches both channels of the servo command parser, keeps its own copy of
// the frame and tokenizer state, predicts the result of every accepted word
// and compares each result word with the oldest prediction.
// ----------------------------------------------------------------------------
module fscp_command_checker #(
  parameter int unsigned FRAME_BYTES = 32
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  fscp_byte_if        byte_mon,
  fscp_result_if      result_mon,
  output int unsigned mismatches,
  output int unsigned outstanding,
  output int unsigned status_hits [4]
);
  import fscp_pkg::*;

  localparam logic [7:0] C_NUL   = 8'h00;
  localparam logic [7:0] C_TAB   = 8'h09;
  localparam logic [7:0] C_LF    = 8'h0A;
  localparam logic [7:0] C_VT    = 8'h0B;
  localparam logic [7:0] C_FF    = 8'h0C;
  localparam logic [7:0] C_CR    = 8'h0D;
  localparam logic [7:0] C_SPACE = 8'h20;
  localparam logic [7:0] C_PLUS  = 8'h2B;
  localparam logic [7:0] C_MINUS = 8'h2D;
  localparam logic [7:0] C_ZERO  = 8'h30;
  localparam logic [7:0] C_NINE  = 8'h39;
  localparam int unsigned REPORT_CAP = 50;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] channel;
    logic [7:0] angle;
  } servo_result_t;

  servo_result_t expected_q [$];

  logic        frame_open;
  int unsigned payload_len;
  logic [3:0]  phase;
  logic [7:0]  num1;
  logic [7:0]  num2;
  logic        neg1;
  logic        neg2;
  logic        truncated;

  function automatic logic is_blank(logic [7:0] c);
    return c inside {C_SPACE, C_TAB, C_CR, C_LF};
  endfunction

  function automatic logic is_vf(logic [7:0] c);
    return c inside {C_VT, C_FF};
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= C_ZERO && c <= C_NINE;
  endfunction

  function automatic logic is_sign(logic [7:0] c);
    return c inside {C_PLUS, C_MINUS};
  endfunction

  function automatic logic [7:0] sat_acc(logic [7:0] v, logic [7:0] c);
    int unsigned n;
    n = int'(v) * 10 + int'(c) - int'(C_ZERO);
    return (n > 255) ? 8'hFF : n[7:0];
  endfunction

  function automatic logic angle_fits(logic [7:0] v, logic neg);
    return neg ? (v == 8'd0) : (v <= MAX_ANGLE);
  endfunction

  function automatic void clear_parser();
    frame_open  = 1'b0;
    payload_len = 0;
    phase       = PH_START;
    num1        = '0;
    num2        = '0;
    neg1        = 1'b0;
    neg2        = 1'b0;
    truncated   = 1'b0;
  endfunction

  function automatic void tokenize(logic [7:0] c);
    logic [3:0] nxt;
    nxt = PH_BAD;
    case (phase)
      PH_START: begin
        if (is_blank(c) || is_vf(c)) begin
          nxt = PH_START;
        end else if (is_sign(c)) begin
          neg1 = (c == C_MINUS);
          nxt  = PH_SIGN1;
        end else if (is_digit(c)) begin
          num1 = sat_acc(num1, c);
          nxt  = PH_DIG1;
        end
      end
      PH_SIGN1, PH_DIG1: begin
        if (is_digit(c)) begin
          num1 = sat_acc(num1, c);
          nxt  = PH_DIG1;
        end else if (phase == PH_DIG1) begin
          if (is_blank(c)) begin
            nxt = PH_GAP;
          end else if (is_vf(c)) begin
            nxt = PH_NEED2;
          end else if (is_sign(c)) begin
            neg2 = (c == C_MINUS);
            nxt  = PH_SIGN2;
          end
        end
      end
      PH_GAP, PH_NEED2: begin
        if (is_blank(c)) begin
          nxt = phase;
        end else if (is_vf(c)) begin
          nxt = PH_NEED2;
        end else if (is_sign(c)) begin
          neg2 = (c == C_MINUS);
          nxt  = PH_SIGN2;
        end else if (is_digit(c)) begin
          num2 = sat_acc(num2, c);
          nxt  = PH_DIG2;
        end
      end
      PH_SIGN2, PH_DIG2: begin
        if (is_digit(c)) begin
          num2 = sat_acc(num2, c);
          nxt  = PH_DIG2;
        end else if (phase == PH_DIG2 && is_blank(c)) begin
          nxt = PH_TRAIL;
        end
      end
      PH_TRAIL: begin
        if (is_blank(c)) nxt = PH_TRAIL;
      end
      default: ;
    endcase
    phase = nxt;
  endfunction

  function automatic logic judge_command(output logic [3:0] ch, output logic [7:0] ang);
    ch  = '0;
    ang = '0;
    if (phase == PH_DIG1 || phase == PH_GAP) begin
      if (!angle_fits(num1, neg1)) return 1'b0;
      ch  = CH_HIGH;
      ang = neg1 ? 8'd0 : num1;
      return 1'b1;
    end
    if (phase == PH_DIG2 || phase == PH_TRAIL) begin
      if (!angle_fits(num2, neg2) || neg1) return 1'b0;
      if (num1 != 8'(CH_LOW) && num1 != 8'(CH_HIGH)) return 1'b0;
      ch  = num1[3:0];
      ang = neg2 ? 8'd0 : num2;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void predict_word(logic overflow_notice, logic [7:0] c);
    servo_result_t r;
    logic [3:0]    ch;
    logic [7:0]    ang;
    r = '0;
    if (overflow_notice) begin
      clear_parser();
      r.status = ST_OVF;
      expected_q.push_back(r);
    end else if (c == HEAD_BYTE) begin
      clear_parser();
      frame_open = 1'b1;
    end else if (c == TAIL_BYTE) begin
      if (frame_open) begin
        if (judge_command(ch, ang)) begin
          r.status  = ST_OK;
          r.channel = ch;
          r.angle   = ang;
        end else begin
          r.status = ST_BAD;
        end
        expected_q.push_back(r);
      end
      clear_parser();
    end else if (frame_open) begin
      if (payload_len >= FRAME_BYTES - 1) begin
        clear_parser();
        r.status = ST_LONG;
        expected_q.push_back(r);
      end else begin
        payload_len++;
        if (!truncated) begin
          if (c == C_NUL) truncated = 1'b1;
          else tokenize(c);
        end
      end
    end
  endfunction

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= REPORT_CAP) $display("[%0t] parser mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin
    servo_result_t seen;
    servo_result_t want;
    if (!rst_n) begin
      clear_parser();
      expected_q.delete();
      mismatches = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    end else begin
      if (result_mon.valid && result_mon.ready) begin
        seen.status  = result_mon.status;
        seen.channel = result_mon.channel;
        seen.angle   = result_mon.angle;
        status_hits[seen.status]++;
        if (expected_q.size() == 0) begin
          report($sformatf("result with none pending: status %0d channel %0d angle %0d",
                           seen.status, seen.channel, seen.angle));
        end else begin
          want = expected_q.pop_front();
          if (seen.status !== want.status)
            report($sformatf("status %0d, wanted %0d", seen.status, want.status));
          if (seen.channel !== want.channel)
            report($sformatf("channel %0d, wanted %0d", seen.channel, want.channel));
          if (seen.angle !== want.angle)
            report($sformatf("angle %0d, wanted %0d", seen.angle, want.angle));
        end
      end
      if (byte_mon.valid && byte_mon.ready) predict_word(byte_mon.func, byte_mon.data_byte);
    end
    outstanding <= expected_q.size();
  end

endmodule : fscp_command_checker

FILE: dv/framed_servo_command_parser_top_tb.sv
// ----------------------------------------------------------------------------
// framed_servo_command_parser_top_tb
// Drives framed command text into the servo command parser: a directed set
// of edge cases first, then random frames (mostly well formed, some damaged,
// overlong or mixed with noise and overflow notices). Both channels idle at
// random; the result side is held off at frames 10 and 30 to stall the input.
// ----------------------------------------------------------------------------
module framed_servo_command_parser_top_tb;
  import fscp_pkg::*;

  localparam int unsigned FRAME_BYTES  = 32;
  localparam int unsigned RANDOM_WORDS = 300;
  localparam int unsigned IDLE_PCT     = 14;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam logic        FN_RX_BYTE   = 1'b0;
  localparam logic        FN_OVERFLOW  = 1'b1;
  localparam logic [7:0]  NUL_BYTE     = 8'h00;
  localparam string       BLANKS4      = " \t\015\n";
  localparam string       ALL_SPACE    = " \t\015\n\013\014";
  localparam string       JUNK         = "+-0123456789 \t\n\013\014\015:x.";

  logic        clk = 1'b0;
  logic        rst_n;
  logic        idling_on = 1'b1;
  logic        hold_req = 1'b0;
  int unsigned words_sent = 0;
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned status_hits [4];
  logic [7:0]  frame_q [$];

  fscp_byte_if   in_ch ();
  fscp_result_if out_ch ();

  framed_servo_command_parser_top #(
    .FRAME_BYTES (FRAME_BYTES)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  fscp_command_checker #(
    .FRAME_BYTES (FRAME_BYTES)
  ) i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_mon    (in_ch),
    .result_mon  (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .status_hits (status_hits)
  );

  always #5 clk = ~clk;

  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

  // result side: random back-pressure, plus long hold-offs on request
  initial begin
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= !(idling_on && $urandom_range(99) < IDLE_PCT);
        @(posedge clk);
      end
    end
  end

  function automatic logic [7:0] pick(string pool);
    return pool[$urandom_range(pool.len() - 1)];
  endfunction

  function automatic string num_text(int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    if ($urandom_range(9) == 0) s = {"0", s};
    return s;
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
  endfunction

  task automatic send_word(input logic fn, input logic [7:0] value);
    while (idling_on && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= fn;
    in_ch.data_byte <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic flush_words();
    while (frame_q.size() != 0) send_word(FN_RX_BYTE, frame_q.pop_front());
  endtask

  task automatic send_frame(input string text);
    frame_q.push_back(HEAD_BYTE);
    push_text(text);
    frame_q.push_back(TAIL_BYTE);
    flush_words();
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    @(posedge clk);
  endtask

  // n payload bytes: blank padding then a two-digit angle
  function automatic void build_padded_frame(int unsigned n);
    frame_q.push_back(HEAD_BYTE);
    repeat (n - 2) frame_q.push_back(pick(ALL_SPACE));
    push_text("45");
    frame_q.push_back(TAIL_BYTE);
  endfunction

  function automatic void build_command_frame();
    int unsigned ang;
    int unsigned k;
    string       sgn;
    k   = $urandom_range(99);
    sgn = (k < 7) ? "-" : (k < 15) ? "+" : "";
    k   = $urandom_range(99);
    if (k < 10) ang = (k < 5) ? 0 : 180;
    else if (k < 80) ang = $urandom_range(180);
    else if (k < 92) ang = $urandom_range(181, 255);
    else ang = $urandom_range(256, 99999);
    if (sgn == "-" && $urandom_range(1)) ang = 0;
    frame_q.push_back(HEAD_BYTE);
    repeat ($urandom_range(0, 2)) frame_q.push_back(pick(ALL_SPACE));
    if ($urandom_range(1)) begin
      k = $urandom_range(99);
      if (k < 4) push_text("-");
      else if (k < 10) push_text("+");
      push_text(num_text((k < 88) ? 13 + $urandom_range(1) : $urandom_range(40)));
      if (sgn == "" || $urandom_range(1)) begin
        repeat ($urandom_range(1, 3)) frame_q.push_back(pick(ALL_SPACE));
      end
    end
    push_text({sgn, num_text(ang)});
    repeat ($urandom_range(0, 2)) frame_q.push_back(pick(BLANKS4));
    k = $urandom_range(99);
    if (k < 4) begin
      frame_q.push_back(pick(ALL_SPACE));
    end else if (k < 9) begin
      frame_q.push_back(NUL_BYTE);
      repeat ($urandom_range(0, 3)) frame_q.push_back(pick(JUNK));
    end
    frame_q.push_back(TAIL_BYTE);
  endfunction

  initial begin
    int unsigned random_start;
    int unsigned frame_no;
    int unsigned k;
    int unsigned idx;

    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.func      <= FN_RX_BYTE;
    in_ch.data_byte <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed cases
    send_frame("90");
    send_frame("13 180");
    send_frame("14\t0");
    send_frame("181");
    send_frame("-0");
    send_frame("-5");
    send_frame("13-0");
    send_frame("14+45");
    send_frame("\013\014 13\01345 \t\015\n");
    send_frame("13 45\013");
    send_frame("");
    send_frame(" \t");
    send_frame("+");
    send_frame("12a");
    send_frame("15 30");
    send_frame("-13 30");
    send_frame("999");
    send_frame("0000090");
    send_frame("13 14 15");
    // zero byte ends the text, later bytes only count toward the length
    frame_q.push_back(HEAD_BYTE);
    push_text("45");
    frame_q.push_back(NUL_BYTE);
    push_text("zz 7");
    frame_q.push_back(TAIL_BYTE);
    frame_q.push_back(HEAD_BYTE);
    frame_q.push_back(NUL_BYTE);
    push_text("90");
    frame_q.push_back(TAIL_BYTE);
    // longest legal payload, then one byte too many; tail then falls outside
    build_padded_frame(FRAME_BYTES - 1);
    build_padded_frame(FRAME_BYTES);
    // head inside a frame restarts it
    frame_q.push_back(HEAD_BYTE);
    push_text("1");
    frame_q.push_back(HEAD_BYTE);
    push_text("77");
    frame_q.push_back(TAIL_BYTE);
    // words outside any frame are ignored
    frame_q.push_back(NUL_BYTE);
    frame_q.push_back(8'hFF);
    frame_q.push_back(TAIL_BYTE);
    push_text("5");
    frame_q.push_back(HEAD_BYTE);
    push_text("13 ");
    flush_words();
    // overflow notice mid-frame drops it
    send_word(FN_OVERFLOW, 8'hFF);
    push_text("45");
    frame_q.push_back(TAIL_BYTE);
    flush_words();
    send_word(FN_OVERFLOW, 8'h00);

    // random frames
    random_start = words_sent;
    frame_no     = 0;
    while (words_sent - random_start < RANDOM_WORDS) begin
      idling_on = !(frame_no >= 15 && frame_no < 28);
      if (frame_no == 10 || frame_no == 30) begin
        hold_req = 1'b1;
        repeat (12) send_word(FN_OVERFLOW, 8'($urandom));
      end
      if (frame_no == 22) wait_drained();
      k = $urandom_range(99);
      if (k < 70) begin
        build_command_frame();
      end else if (k < 80) begin
        build_command_frame();
        idx = $urandom_range(1, frame_q.size() - 2);
        case ($urandom_range(2))
          0: frame_q[idx] = $urandom_range(1) ? pick(JUNK) : 8'($urandom);
          1: frame_q.insert(idx, pick(JUNK));
          default: void'(frame_q.pop_back());
        endcase
      end else if (k < 87) begin
        frame_q.push_back(HEAD_BYTE);
        repeat ($urandom_range(0, 6)) frame_q.push_back(pick(JUNK));
        frame_q.push_back(TAIL_BYTE);
      end else if (k < 91) begin
        build_padded_frame($urandom_range(FRAME_BYTES - 3, FRAME_BYTES + 2));
      end else if (k < 96) begin
        repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom));
      end else begin
        send_word(FN_OVERFLOW, 8'($urandom));
      end
      flush_words();
      frame_no++;
    end

    idling_on = 1'b1;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    $display("Run covered %0d words (%0d random frames) with %0d results:",
             words_sent, frame_no,
             status_hits[ST_OK] + status_hits[ST_BAD] + status_hits[ST_LONG]
             + status_hits[ST_OVF]);
    $display("  ok %0d, bad command %0d, frame too long %0d, overflow %0d",
             status_hits[ST_OK], status_hits[ST_BAD], status_hits[ST_LONG],
             status_hits[ST_OVF]);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule : framed_servo_command_parser_top_tb
